>>> rtl/fdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_pkg
// Shared types and constants of the direct-form FIR filter unit.
// ----------------------------------------------------------------------------
package fdf_pkg;

  localparam int SMP_W     = 16;
  localparam int COEF_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int TAPC_W    = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int RND_SHIFT = 27;

  localparam logic [1:0] MODE_FILT = 2'd0;
  localparam logic [1:0] MODE_COEF = 2'd1;
  localparam logic [1:0] MODE_CLR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;

  localparam logic [1:0] OP_TAP = 2'd0;
  localparam logic [1:0] OP_GLO = 2'd1;
  localparam logic [1:0] OP_GHI = 2'd2;

  typedef struct packed {
    logic [1:0] sel;
    logic       acc_clr;
    logic       tap_v;
    logic       tap_m;
    logic       scl_ld;
    logic       scl_add;
    logic       rnd_ld;
  } fdf_mac_ctl_t;

endpackage

>>> rtl/fdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fdf_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_mac
// Shared multiplier with tap accumulator, gain scaling, rounding, saturation.
// ----------------------------------------------------------------------------
module fdf_mac #(
  parameter int ACC_W = 38
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fdf_pkg::fdf_mac_ctl_t       ctl,
  input  logic signed [15:0]          smp,
  input  logic signed [15:0]          coef,
  input  logic [15:0]                 gain,
  output logic signed [15:0]          sat
);
  import fdf_pkg::*;

  localparam int MUL_A_W = ((ACC_W - 16) > 17) ? (ACC_W - 16) : 17;
  localparam int PROD_W  = MUL_A_W + 17;
  localparam int SCL_W   = ACC_W + 17;
  localparam int RND_W   = SCL_W + 1 - RND_SHIFT;
  localparam logic [SCL_W:0] RND_HALF =
    {{(SCL_W + 1 - RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT - 1){1'b0}}};
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [16:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      v2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SCL_W-1:0]   scl_r;
  logic signed [SCL_W:0]     rnd_sum;
  logic signed [RND_W-1:0]   rnd_r;

  always_comb begin
    unique case (ctl.sel)
      OP_TAP: begin
        mul_a = ctl.tap_m ? MUL_A_W'(smp) : '0;
        mul_b = 17'(coef);
      end
      OP_GLO: begin
        mul_a = MUL_A_W'({1'b0, acc_r[15:0]});
        mul_b = {1'b0, gain};
      end
      OP_GHI: begin
        mul_a = MUL_A_W'($signed(acc_r[ACC_W-1:16]));
        mul_b = {1'b0, gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd_sum = (SCL_W + 1)'(scl_r) + $signed(RND_HALF);

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (ctl.scl_ld) begin
      scl_r <= SCL_W'(prod_r);
    end else if (ctl.scl_add) begin
      scl_r <= scl_r + (SCL_W'(prod_r) <<< 16);
    end
    if (ctl.rnd_ld) begin
      rnd_r <= rnd_sum[SCL_W:RND_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r  <= 1'b0;
      acc_r <= '0;
    end else if (ctl.acc_clr) begin
      v2_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v2_r <= ctl.tap_v;
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'($signed(prod_r[31:0]));
      end
    end
  end

  always_comb begin
    if (rnd_r > SAT_HI) begin
      sat = 16'sh7fff;
    end else if (rnd_r < SAT_LO) begin
      sat = 16'sh8000;
    end else begin
      sat = rnd_r[15:0];
    end
  end

endmodule

>>> rtl/fir_filter_direct_form_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_direct_form_unit
// Direct-form FIR filter; one shared multiplier walks the taps in sequence.
// ----------------------------------------------------------------------------
// Filter item: after accept, taps (tap_count clamped to MAX_TAPS) are walked
//   with one multiply per tap; in_ready stays low until out_valid is raised.
// A result held by out_ready low stalls the unit in its last state.
// Coefficient write, delay-line clear and unused modes complete in S_IDLE.
// Reset: after rst_n an S_CLR pass zeroes the coefficient RAM with
//   in_ready low; the delay line is cleared at once through its fill count.
// ----------------------------------------------------------------------------
module fir_filter_direct_form_unit #(
  parameter int MAX_TAPS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_mode,
  input  logic signed [15:0]                 in_sample_in,
  input  logic [5:0]                         in_coef_index,
  input  logic signed [15:0]                 in_coef_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_sample_out,
  input  logic                               cfg_we,
  input  logic [fdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdf_pkg::CFG_W-1:0]          cfg_wdata
);
  import fdf_pkg::*;

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 32 + $clog2(MAX_TAPS);
  localparam int TCMP_W = (CNT_W > TAPC_W) ? CNT_W : TAPC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MAC  = 4'd2;
  localparam logic [3:0] S_DRN1 = 4'd3;
  localparam logic [3:0] S_DRN2 = 4'd4;
  localparam logic [3:0] S_GLO  = 4'd5;
  localparam logic [3:0] S_GHI  = 4'd6;
  localparam logic [3:0] S_GSUM = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic                v1_r, v1_nxt;
  logic                m1_r, m1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [15:0]  out_data_r, out_data_nxt;
  logic [TAPC_W-1:0]   tap_count_r;
  logic [GAIN_W-1:0]   gain_r;

  logic                accept;
  logic [TCMP_W-1:0]   tc_ext;
  logic [CNT_W-1:0]    taps_w;
  logic [IDX_W-1:0]    ptr_inc;
  logic [IDX_W-1:0]    ptr_dec;
  logic                idx_ok;
  logic                co_we;
  logic [IDX_W-1:0]    co_waddr;
  logic [COEF_W-1:0]   co_wdata;
  logic [COEF_W-1:0]   co_rdata;
  logic                dl_we;
  logic [SMP_W-1:0]    dl_rdata;
  logic signed [15:0]  sat;
  fdf_mac_ctl_t        ctl;

  assign in_ready       = (state_r == S_IDLE);
  assign accept         = in_valid & in_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  assign tc_ext  = TCMP_W'(tap_count_r);
  assign taps_w  = (tc_ext > TCMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tc_ext);
  assign ptr_inc = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
  assign ptr_dec = (rd_ptr_r == '0) ? LAST_IDX : rd_ptr_r - 1'b1;
  assign idx_ok  = (int'(in_coef_index) < MAX_TAPS);

  assign co_we    = (state_r == S_CLR) || (accept && (in_mode == MODE_COEF) && idx_ok);
  assign co_waddr = (state_r == S_CLR) ? cnt_r[IDX_W-1:0] : IDX_W'(in_coef_index);
  assign co_wdata = (state_r == S_CLR) ? '0 : in_coef_value;
  assign dl_we    = accept && (in_mode == MODE_FILT);

  fdf_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (co_we),
    .waddr (co_waddr),
    .wdata (co_wdata),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (co_rdata)
  );

  fdf_ram #(.WIDTH(SMP_W), .DEPTH(MAX_TAPS)) u_dly_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (ptr_inc),
    .wdata (in_sample_in),
    .raddr (rd_ptr_r),
    .rdata (dl_rdata)
  );

  fdf_mac #(.ACC_W(ACC_W)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .smp   (dl_rdata),
    .coef  (co_rdata),
    .gain  (gain_r),
    .sat   (sat)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    v1_nxt        = 1'b0;
    m1_nxt        = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.sel       = OP_TAP;
    ctl.tap_v     = v1_r;
    ctl.tap_m     = m1_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[IDX_W-1:0] == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_FILT: begin
              wr_ptr_nxt  = ptr_inc;
              rd_ptr_nxt  = ptr_inc;
              fill_nxt    = (fill_r == CNT_W'(MAX_TAPS)) ? fill_r : fill_r + 1'b1;
              cnt_nxt     = '0;
              ctl.acc_clr = 1'b1;
              state_nxt   = (taps_w == '0) ? S_DRN1 : S_MAC;
            end
            MODE_COEF: begin
            end
            MODE_CLR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MAC: begin
        v1_nxt     = 1'b1;
        m1_nxt     = (cnt_r < fill_r);
        cnt_nxt    = cnt_r + 1'b1;
        rd_ptr_nxt = ptr_dec;
        if (CNT_W'(cnt_r + 1'b1) == taps_w) begin
          state_nxt = S_DRN1;
        end
      end
      S_DRN1: state_nxt = S_DRN2;
      S_DRN2: state_nxt = S_GLO;
      S_GLO: begin
        ctl.sel   = OP_GLO;
        state_nxt = S_GHI;
      end
      S_GHI: begin
        ctl.sel    = OP_GHI;
        ctl.scl_ld = 1'b1;
        state_nxt  = S_GSUM;
      end
      S_GSUM: begin
        ctl.scl_add = 1'b1;
        state_nxt   = S_RND;
      end
      S_RND: begin
        ctl.rnd_ld = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      fill_r      <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      v1_r        <= 1'b0;
      m1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      v1_r        <= v1_nxt;
      m1_r        <= m1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPC_W'(64);
      gain_r      <= GAIN_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAP_COUNT: tap_count_r <= cfg_wdata[TAPC_W-1:0];
        REG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_TAPS))
    else $error("fill count above depth");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (cnt_r < taps_w))
    else $error("tap counter past tap count");

  a_tap_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> $past(state_r == S_MAC))
    else $error("tap data valid outside tap walk");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(wr_ptr_r) < MAX_TAPS) && (int'(rd_ptr_r) < MAX_TAPS))
    else $error("delay pointer out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result dropped while output slot busy");

endmodule
